// ===== rtl/twodo_pkg.sv =====
// ----------------------------------------------------------------------------
// twodo_pkg
// Shared types, constants and tables for the tracking-wheel odometry core.
// ----------------------------------------------------------------------------
package twodo_pkg;

   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int POSITION_BITS_DEF = 40;

   localparam int MUL_A_BITS = 50;
   localparam int MUL_B_BITS = 34;
   localparam int PROD_BITS  = 84;
   localparam int DIV_BITS   = 80;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [15:0] DIV_DEG     = 16'd36000;
   localparam logic [15:0] DIV_HALF    = 16'd18000;
   localparam logic [15:0] DIV_QUARTER = 16'd9000;

   localparam logic [29:0]        PI_Q28   = 30'd843314857;
   localparam logic signed [32:0] KINV_Q30 = 33'sd652032874;

   localparam logic [15:0]        CIRC_RESET     = 16'd40856;
   localparam logic signed [15:0] FWD_OFF_RESET  = -16'sd24320;
   localparam logic signed [15:0] SIDE_OFF_RESET = 16'sd8192;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CIRC     = 2'd0,
      CSR_FWD_OFF  = 2'd1,
      CSR_SIDE_OFF = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] forward_angle;
      logic signed [31:0] sideways_angle;
      logic signed [31:0] heading_angle;
   } req_type;

   typedef struct packed {
      logic signed [39:0] position_x;
      logic signed [39:0] position_y;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_DF,
      ST_DIV_DF,
      ST_MUL_DS,
      ST_DIV_DS,
      ST_MUL_PS,
      ST_MUL_TS,
      ST_DIV_TS,
      ST_MUL_PF,
      ST_MUL_TF,
      ST_DIV_TF,
      ST_LOCAL,
      ST_DIV_H,
      ST_CORDIC,
      ST_MUL_Y1,
      ST_MUL_Y2,
      ST_MUL_X1,
      ST_MUL_X2,
      ST_ACC
   } state_type;

   // atan(2^-i) in 1/6553600 degree
   function automatic logic [28:0] atan_entry(input logic [4:0] i);
      logic [28:0] v;
      case (i)
         5'd0:  v = 29'd294912000;
         5'd1:  v = 29'd174096719;
         5'd2:  v = 29'd91987925;
         5'd3:  v = 29'd46694507;
         5'd4:  v = 29'd23437865;
         5'd5:  v = 29'd11730358;
         5'd6:  v = 29'd5866610;
         5'd7:  v = 29'd2933485;
         5'd8:  v = 29'd1466764;
         5'd9:  v = 29'd733385;
         5'd10: v = 29'd366693;
         5'd11: v = 29'd183347;
         5'd12: v = 29'd91673;
         5'd13: v = 29'd45837;
         5'd14: v = 29'd22919;
         5'd15: v = 29'd11459;
         5'd16: v = 29'd5730;
         5'd17: v = 29'd2865;
         5'd18: v = 29'd1432;
         5'd19: v = 29'd716;
         5'd20: v = 29'd358;
         5'd21: v = 29'd179;
         5'd22: v = 29'd90;
         5'd23: v = 29'd45;
         default: v = 29'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/twodo_mul.sv =====
// ----------------------------------------------------------------------------
// twodo_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module twodo_mul (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic signed [twodo_pkg::MUL_A_BITS-1:0]   a,
   input  logic signed [twodo_pkg::MUL_B_BITS-1:0]   b,
   output logic                                      done,
   output logic signed [twodo_pkg::PROD_BITS-1:0]    product
);

   localparam int AW = twodo_pkg::MUL_A_BITS;
   localparam int BW = twodo_pkg::MUL_B_BITS;
   localparam int PW = twodo_pkg::PROD_BITS;

   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0] mplier_ff, mplier_in;
   logic          neg_ff, neg_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [AW-1:0] a_mag;
   logic [BW-1:0] b_mag;

   assign a_mag = a[AW-1] ? AW'(-a) : AW'(a);
   assign b_mag = b[BW-1] ? BW'(-b) : BW'(b);

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PW'(a_mag);
         mplier_in = b_mag;
         neg_in    = a[AW-1] ^ b[BW-1];
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PW-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[BW-1:1]};
         cnt_in    = cnt_ff + 6'd1;
         if (cnt_ff == 6'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = neg_ff ? -signed'(acc_ff) : signed'(acc_ff);

endmodule

// ===== rtl/twodo_div.sv =====
// ----------------------------------------------------------------------------
// twodo_div
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module twodo_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [twodo_pkg::DIV_BITS-1:0]     num,
   input  logic [15:0]                        den,
   output logic                               done,
   output logic [twodo_pkg::DIV_BITS-1:0]     quot,
   output logic [15:0]                        rem
);

   localparam int DW = twodo_pkg::DIV_BITS;

   logic [DW-1:0] quo_ff, quo_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   den_ff, den_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [16:0]   trial;
   logic [16:0]   diff;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/twodo_cordic.sv =====
// ----------------------------------------------------------------------------
// twodo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module twodo_cordic #(
   parameter int CORDIC_STEPS = twodo_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [14:0] angle,
   input  logic               negate,
   output logic               done,
   output logic signed [32:0] cos_q30,
   output logic signed [32:0] sin_q30
);

   localparam int CW = $clog2(CORDIC_STEPS + 1);

   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [32:0] xs, ys;
   logic signed [31:0] at;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = signed'({3'b000, twodo_pkg::atan_entry(5'(cnt_ff))});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = twodo_pkg::KINV_Q30;
         y_in    = '0;
         z_in    = {angle[14], angle, 16'h0000};
         cnt_in  = '0;
         neg_in  = negate;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign cos_q30 = neg_ff ? -x_ff : x_ff;
   assign sin_q30 = neg_ff ? -y_ff : y_ff;

endmodule

// ===== rtl/tracking_wheel_odometry_core.sv =====
// One transaction at a time: a request is taken only in ST_IDLE, and a finished result
// is held in ST_ACC while an earlier response still waits for rsp_ready.
// Each transaction uses the shared bit-serial multiplier (ten uses), the shared divider
// (five uses) and the CORDIC in turn.
// Reset: synchronous; CSRs load defaults; state, previous angles, X/Y accumulators cleared.
// ----------------------------------------------------------------------------
// tracking_wheel_odometry_core
// Two-wheel odometry with IMU heading: wheel travel, arc correction, CORDIC
// rotation and saturating global X/Y accumulation.
// ----------------------------------------------------------------------------
module tracking_wheel_odometry_core #(
   parameter int CORDIC_STEPS  = twodo_pkg::CORDIC_STEPS_DEF,
   parameter int POSITION_BITS = twodo_pkg::POSITION_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  twodo_pkg::req_type                      req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output twodo_pkg::rsp_type                      rsp_payload,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [twodo_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [twodo_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int AW = twodo_pkg::MUL_A_BITS;
   localparam int BW = twodo_pkg::MUL_B_BITS;
   localparam int PW = twodo_pkg::PROD_BITS;
   localparam int DW = twodo_pkg::DIV_BITS;
   localparam int P  = POSITION_BITS;

   localparam logic signed [71:0] ACC_MAX   = (72'sd1 <<< (P - 1)) - 72'sd1;
   localparam logic signed [71:0] ACC_MIN   = -ACC_MAX - 72'sd1;
   localparam logic signed [38:0] LOCAL_LIM = 39'sd4294967295;

   twodo_pkg::state_type state_ff, state_in;
   logic busy_ff, busy_in;

   logic [15:0]        circ_ff, circ_in;
   logic signed [15:0] fwd_off_ff, fwd_off_in, side_off_ff, side_off_in;
   logic signed [31:0] prev_f_ff, prev_f_in, prev_s_ff, prev_s_in, prev_h_ff, prev_h_in;
   logic signed [P-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] head_ff, head_in;
   logic signed [32:0] d_f_ff, d_f_in, d_s_ff, d_s_in, d_h_ff, d_h_in;
   logic signed [PW-1:0] work_ff, work_in, sum_ff, sum_in;
   logic psign_ff, psign_in;
   logic signed [35:0] df_ff, df_in, ds_ff, ds_in;
   logic signed [37:0] arc_s_ff, arc_s_in, arc_f_ff, arc_f_in;
   logic signed [32:0] lf_ff, lf_in, ls_ff, ls_in;
   logic signed [14:0] ang_ff, ang_in;
   logic hneg_ff, hneg_in;
   logic signed [32:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [53:0] dx_ff, dx_in, dy_ff, dy_in;
   twodo_pkg::rsp_type out_ff, out_in;

   logic mul_start, mul_done, div_start, div_done, cor_start, cor_done;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_prod;
   logic [DW-1:0] div_num, div_quot;
   logic [15:0]   div_den, div_rem;
   logic signed [32:0] cor_cos, cor_sin;

   logic [PW-1:0]      work_mag;
   logic signed [35:0] q_signed;
   logic [DW-1:0]      round_sum;
   logic signed [37:0] arc_val;
   logic signed [38:0] lf_sum, ls_sum;
   logic [31:0]        h_mag;
   logic [16:0]        amod;
   logic signed [17:0] awrap;
   logic signed [PW-1:0] y_tot, x_tot;
   logic signed [71:0] sx_sum, sy_sum, sx_sat, sy_sat;
   logic out_free;

   twodo_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_prod)
   );

   twodo_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot), .rem(div_rem)
   );

   twodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(ang_ff), .negate(hneg_ff),
      .done(cor_done), .cos_q30(cor_cos), .sin_q30(cor_sin)
   );

   function automatic logic signed [32:0] clamp_local(input logic signed [38:0] v);
      logic signed [38:0] r;
      r = v;
      if (v > LOCAL_LIM) begin
         r = LOCAL_LIM;
      end else if (v < -LOCAL_LIM) begin
         r = -LOCAL_LIM;
      end
      return r[32:0];
   endfunction

   function automatic logic signed [71:0] sat72(input logic signed [71:0] v);
      logic signed [71:0] r;
      r = v;
      if (v > ACC_MAX) begin
         r = ACC_MAX;
      end else if (v < ACC_MIN) begin
         r = ACC_MIN;
      end
      return r;
   endfunction

   assign work_mag  = work_ff[PW-1] ? PW'(-work_ff) : PW'(work_ff);
   assign q_signed  = work_ff[PW-1] ? -signed'({1'b0, div_quot[34:0]})
                                    : signed'({1'b0, div_quot[34:0]});
   assign round_sum = div_quot + (DW'(1) << 27);
   assign arc_val   = psign_ff ? -signed'({1'b0, round_sum[64:28]})
                               : signed'({1'b0, round_sum[64:28]});
   assign lf_sum    = 39'(df_ff) - 39'(arc_s_ff);
   assign ls_sum    = 39'(ds_ff) + 39'(arc_f_ff);
   assign h_mag     = 32'(head_ff[31] ? -head_ff : head_ff);
   assign amod      = (head_ff[31] && div_rem != 16'd0) ?
                      17'(twodo_pkg::DIV_DEG) - 17'(div_rem) : 17'(div_rem);
   assign awrap     = (amod > 17'(twodo_pkg::DIV_HALF)) ?
                      signed'(18'(amod)) - signed'(18'(twodo_pkg::DIV_DEG)) :
                      signed'(18'(amod));
   assign y_tot     = sum_ff + mul_prod + (PW'(1) << 29);
   assign x_tot     = sum_ff - mul_prod + (PW'(1) << 29);
   assign sx_sum    = 72'(acc_x_ff) + 72'(dx_ff);
   assign sy_sum    = 72'(acc_y_ff) + 72'(dy_ff);
   assign sx_sat    = sat72(sx_sum);
   assign sy_sat    = sat72(sy_sum);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      circ_in      = circ_ff;
      fwd_off_in   = fwd_off_ff;
      side_off_in  = side_off_ff;
      prev_f_in    = prev_f_ff;
      prev_s_in    = prev_s_ff;
      prev_h_in    = prev_h_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      head_in      = head_ff;
      d_f_in       = d_f_ff;
      d_s_in       = d_s_ff;
      d_h_in       = d_h_ff;
      work_in      = work_ff;
      sum_in       = sum_ff;
      psign_in     = psign_ff;
      df_in        = df_ff;
      ds_in        = ds_ff;
      arc_s_in     = arc_s_ff;
      arc_f_in     = arc_f_ff;
      lf_in        = lf_ff;
      ls_in        = ls_ff;
      ang_in       = ang_ff;
      hneg_in      = hneg_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      out_in       = out_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = twodo_pkg::DIV_DEG;
      cor_start    = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            twodo_pkg::CSR_CIRC:     circ_in     = csr_data;
            twodo_pkg::CSR_FWD_OFF:  fwd_off_in  = signed'(csr_data);
            twodo_pkg::CSR_SIDE_OFF: side_off_in = signed'(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         twodo_pkg::ST_IDLE: begin
            if (req_valid) begin
               prev_f_in = req_payload.forward_angle;
               prev_s_in = req_payload.sideways_angle;
               prev_h_in = req_payload.heading_angle;
               head_in   = req_payload.heading_angle;
               d_f_in    = 33'(req_payload.forward_angle) - 33'(prev_f_ff);
               d_s_in    = 33'(req_payload.sideways_angle) - 33'(prev_s_ff);
               d_h_in    = 33'(req_payload.heading_angle) - 33'(prev_h_ff);
               state_in  = twodo_pkg::ST_MUL_DF;
            end
         end
         twodo_pkg::ST_MUL_DF, twodo_pkg::ST_MUL_DS: begin
            mul_a     = (state_ff == twodo_pkg::ST_MUL_DF) ? AW'(d_f_ff) : AW'(d_s_ff);
            mul_b     = signed'(BW'(circ_ff));
            mul_start = !busy_ff;
            if (mul_done) begin
               work_in  = mul_prod;
               state_in = (state_ff == twodo_pkg::ST_MUL_DF) ? twodo_pkg::ST_DIV_DF
                                                             : twodo_pkg::ST_DIV_DS;
            end
         end
         twodo_pkg::ST_DIV_DF, twodo_pkg::ST_DIV_DS: begin
            div_num   = work_mag[DW-1:0] + DW'(twodo_pkg::DIV_HALF);
            div_den   = twodo_pkg::DIV_DEG;
            div_start = !busy_ff;
            if (div_done) begin
               if (state_ff == twodo_pkg::ST_DIV_DF) begin
                  df_in    = q_signed;
                  state_in = twodo_pkg::ST_MUL_DS;
               end else begin
                  ds_in    = q_signed;
                  state_in = twodo_pkg::ST_MUL_PS;
               end
            end
         end
         twodo_pkg::ST_MUL_PS, twodo_pkg::ST_MUL_PF: begin
            mul_a     = (state_ff == twodo_pkg::ST_MUL_PS) ? AW'(side_off_ff) : AW'(fwd_off_ff);
            mul_b     = BW'(d_h_ff);
            mul_start = !busy_ff;
            if (mul_done) begin
               work_in  = mul_prod;
               psign_in = mul_prod[PW-1];
               state_in = (state_ff == twodo_pkg::ST_MUL_PS) ? twodo_pkg::ST_MUL_TS
                                                             : twodo_pkg::ST_MUL_TF;
            end
         end
         twodo_pkg::ST_MUL_TS, twodo_pkg::ST_MUL_TF: begin
            mul_a     = signed'(work_mag[AW-1:0]);
            mul_b     = signed'(BW'(twodo_pkg::PI_Q28));
            mul_start = !busy_ff;
            if (mul_done) begin
               work_in  = mul_prod;
               state_in = (state_ff == twodo_pkg::ST_MUL_TS) ? twodo_pkg::ST_DIV_TS
                                                             : twodo_pkg::ST_DIV_TF;
            end
         end
         twodo_pkg::ST_DIV_TS, twodo_pkg::ST_DIV_TF: begin
            div_num   = work_ff[DW-1:0] + DW'(twodo_pkg::DIV_QUARTER);
            div_den   = twodo_pkg::DIV_HALF;
            div_start = !busy_ff;
            if (div_done) begin
               if (state_ff == twodo_pkg::ST_DIV_TS) begin
                  arc_s_in = arc_val;
                  state_in = twodo_pkg::ST_MUL_PF;
               end else begin
                  arc_f_in = arc_val;
                  state_in = twodo_pkg::ST_LOCAL;
               end
            end
         end
         twodo_pkg::ST_LOCAL: begin
            lf_in    = clamp_local(lf_sum);
            ls_in    = clamp_local(ls_sum);
            state_in = twodo_pkg::ST_DIV_H;
         end
         twodo_pkg::ST_DIV_H: begin
            div_num   = DW'(h_mag);
            div_den   = twodo_pkg::DIV_DEG;
            div_start = !busy_ff;
            if (div_done) begin
               // fold into +/- a quarter turn, negate the result when folded
               if (awrap > signed'(18'(twodo_pkg::DIV_QUARTER))) begin
                  ang_in  = 15'(awrap - signed'(18'(twodo_pkg::DIV_HALF)));
                  hneg_in = 1'b1;
               end else if (awrap < -signed'(18'(twodo_pkg::DIV_QUARTER))) begin
                  ang_in  = 15'(awrap + signed'(18'(twodo_pkg::DIV_HALF)));
                  hneg_in = 1'b1;
               end else begin
                  ang_in  = 15'(awrap);
                  hneg_in = 1'b0;
               end
               state_in = twodo_pkg::ST_CORDIC;
            end
         end
         twodo_pkg::ST_CORDIC: begin
            cor_start = !busy_ff;
            if (cor_done) begin
               cos_in   = cor_cos;
               sin_in   = cor_sin;
               state_in = twodo_pkg::ST_MUL_Y1;
            end
         end
         twodo_pkg::ST_MUL_Y1: begin
            mul_a     = AW'(lf_ff);
            mul_b     = BW'(cos_ff);
            mul_start = !busy_ff;
            if (mul_done) begin
               sum_in   = mul_prod;
               state_in = twodo_pkg::ST_MUL_Y2;
            end
         end
         twodo_pkg::ST_MUL_Y2: begin
            mul_a     = AW'(ls_ff);
            mul_b     = BW'(sin_ff);
            mul_start = !busy_ff;
            if (mul_done) begin
               dy_in    = y_tot[PW-1:30];
               state_in = twodo_pkg::ST_MUL_X1;
            end
         end
         twodo_pkg::ST_MUL_X1: begin
            mul_a     = AW'(ls_ff);
            mul_b     = BW'(cos_ff);
            mul_start = !busy_ff;
            if (mul_done) begin
               sum_in   = mul_prod;
               state_in = twodo_pkg::ST_MUL_X2;
            end
         end
         twodo_pkg::ST_MUL_X2: begin
            mul_a     = AW'(lf_ff);
            mul_b     = BW'(sin_ff);
            mul_start = !busy_ff;
            if (mul_done) begin
               dx_in    = x_tot[PW-1:30];
               state_in = twodo_pkg::ST_ACC;
            end
         end
         twodo_pkg::ST_ACC: begin
            if (out_free) begin
               acc_x_in              = sx_sat[P-1:0];
               acc_y_in              = sy_sat[P-1:0];
               out_in.position_x     = sx_sat[39:0];
               out_in.position_y     = sy_sat[39:0];
               rsp_valid_in          = 1'b1;
               state_in              = twodo_pkg::ST_IDLE;
            end
         end
         default: state_in = twodo_pkg::ST_IDLE;
      endcase
   end

   assign busy_in = mul_start || div_start || cor_start ||
                    (busy_ff && !(mul_done || div_done || cor_done));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twodo_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         circ_ff      <= twodo_pkg::CIRC_RESET;
         fwd_off_ff   <= twodo_pkg::FWD_OFF_RESET;
         side_off_ff  <= twodo_pkg::SIDE_OFF_RESET;
         prev_f_ff    <= '0;
         prev_s_ff    <= '0;
         prev_h_ff    <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         circ_ff      <= circ_in;
         fwd_off_ff   <= fwd_off_in;
         side_off_ff  <= side_off_in;
         prev_f_ff    <= prev_f_in;
         prev_s_ff    <= prev_s_in;
         prev_h_ff    <= prev_h_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      d_f_ff   <= d_f_in;
      d_s_ff   <= d_s_in;
      d_h_ff   <= d_h_in;
      work_ff  <= work_in;
      sum_ff   <= sum_in;
      psign_ff <= psign_in;
      df_ff    <= df_in;
      ds_ff    <= ds_in;
      arc_s_ff <= arc_s_in;
      arc_f_ff <= arc_f_in;
      lf_ff    <= lf_in;
      ls_ff    <= ls_in;
      ang_ff   <= ang_in;
      hneg_ff  <= hneg_in;
      cos_ff   <= cos_in;
      sin_ff   <= sin_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      out_ff   <= out_in;
   end

   assign req_ready   = (state_ff == twodo_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = out_ff;

`ifndef NO_ASSERTIONS
   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while a transaction is in progress");

   a_acc_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twodo_pkg::ST_ACC) && out_free |=> rsp_valid && req_ready)
      else $error("finished transaction not presented on the response side");

   a_unit_done_owned: assert property (@(posedge clock) disable iff (reset)
      mul_done || div_done || cor_done |-> busy_ff &&
      $countones({mul_done, div_done, cor_done}) == 1)
      else $error("arithmetic unit completion without an owner");
`endif

endmodule
